FILE: hdl/mclfr_pkg.sv
// Shared types and constants for the multi-channel LED fade ramp.
package mclfr_pkg;

  localparam int CH_W  = 2;
  localparam int LVL_W = 8;

  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // One channel's stored state.
  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] goal;
    dir_t             dir;
  } rec_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_channel;
    logic [LVL_W-1:0] pwm_level;
    logic             level_written;
    logic             fading;
  } result_t;

endpackage

FILE: hdl/mclfr_item_if.sv
// Input channel: set-target and tick beats.
interface mclfr_item_if;
  import mclfr_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [CH_W-1:0]  channel;
  logic [LVL_W-1:0] target_level;

  modport source (output valid, kind, channel, target_level, input ready);
  modport sink (input valid, kind, channel, target_level, output ready);
endinterface

FILE: hdl/mclfr_result_if.sv
// Output channel: one result beat per input beat.
interface mclfr_result_if;
  import mclfr_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  out_channel;
  logic [LVL_W-1:0] pwm_level;
  logic             level_written;
  logic             fading;

  modport source (output valid, out_channel, pwm_level, level_written, fading, input ready);
  modport sink (input valid, out_channel, pwm_level, level_written, fading, output ready);
endinterface

FILE: hdl/mclfr_state_mem.sv
// Per-channel state memory with registered read data, valid bits and write forwarding.
module mclfr_state_mem #(
  parameter int CHANNELS = 4,
  parameter int AW       = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  mclfr_pkg::rec_t   wr_rec,
  output mclfr_pkg::rec_t   rd_rec
);
  import mclfr_pkg::*;

  rec_t                mem [CHANNELS];
  logic [CHANNELS-1:0] vld;
  rec_t                ram_q;
  rec_t                fwd_q;
  logic                vld_q;
  logic                hit_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
        hit_q <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // A write in the same cycle as a read of that entry is not yet in the
  // array, so its record is kept aside and takes precedence.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      ram_q <= mem[rd_addr];
      fwd_q <= wr_rec;
    end
  end

  assign rd_rec = hit_q ? fwd_q : (vld_q ? ram_q : '0);

  a_reset_clears_valid: assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("valid bits not cleared by reset");

  a_forward_on_collision: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en && (rd_addr == wr_addr)) |=> hit_q)
    else $error("same-entry read and write not forwarded");

  a_no_stale_forward: assert property (@(posedge clk) disable iff (rst)
    (rd_en && !wr_en) |=> !hit_q)
    else $error("forwarding flagged without a write");

endmodule

FILE: hdl/mclfr_update.sv
// Fade step logic: works out a channel's new state and the result from one beat.
module mclfr_update #(
  parameter int STEP_SIZE = 2
) (
  input  logic                           kind,
  input  logic [mclfr_pkg::CH_W-1:0]     channel,
  input  logic [mclfr_pkg::LVL_W-1:0]    target_level,
  input  logic                           in_range,
  input  mclfr_pkg::rec_t                cur,
  output mclfr_pkg::rec_t                nxt,
  output mclfr_pkg::result_t             res
);
  import mclfr_pkg::*;

  localparam int               STEP_EFF = (STEP_SIZE == 0) ? 1 : STEP_SIZE;
  localparam logic [LVL_W-1:0] STEP     = LVL_W'(STEP_EFF);

  logic [LVL_W-1:0] gap;
  logic [LVL_W-1:0] remain;
  logic             written;

  always_comb begin
    nxt     = cur;
    written = 1'b0;
    gap     = (target_level > cur.level) ? (target_level - cur.level)
                                         : (cur.level - target_level);
    remain  = (cur.dir == DIR_UP) ? (cur.goal - cur.level) : (cur.level - cur.goal);

    if (kind == KIND_SET) begin
      if (cur.dir == DIR_IDLE && target_level != cur.level) begin
        written  = 1'b1;
        nxt.goal = target_level;
        if (gap <= STEP) begin
          nxt.level = target_level;
          nxt.dir   = DIR_IDLE;
        end else if (target_level > cur.level) begin
          nxt.level = cur.level + STEP;
          nxt.dir   = DIR_UP;
        end else begin
          nxt.level = cur.level - STEP;
          nxt.dir   = DIR_DOWN;
        end
      end
    end else if (cur.dir != DIR_IDLE) begin
      // More than one step is left exactly when the remaining gap exceeds
      // one step; otherwise the level snaps onto the goal.
      written = 1'b1;
      if (remain > STEP) begin
        nxt.level = (cur.dir == DIR_UP) ? (cur.level + STEP) : (cur.level - STEP);
      end else begin
        nxt.level = cur.goal;
        nxt.dir   = DIR_IDLE;
      end
    end

    res.out_channel   = channel;
    res.pwm_level     = in_range ? nxt.level : '0;
    res.level_written = in_range && written;
    res.fading        = in_range && (nxt.dir != DIR_IDLE);
  end

endmodule

FILE: hdl/multi_channel_led_fade_ramp_top.sv
// Top level of the multi-channel LED fade ramp.
//
// The item channel takes set-target beats (kind 0) and fade ticks (kind 1)
// for one LED channel each; the result channel returns exactly one beat per
// item, in order, carrying the channel's PWM level after that item, whether
// the level was written, and whether the channel is still fading.
// Channel state sits in a small memory that is read when the item is taken;
// the step is computed from the read data and written back while the
// result is loaded into the output register. A back-to-back item for the
// same channel takes the freshly written state through a forwarding path.
// An item passes the read stage and then the output register before its
// result beat is offered, and the block takes one item every cycle while
// results are being drained.
// Reset clears every channel to level zero and idle through per-entry valid
// bits, so items are accepted as soon as reset is released.
// When the receiver stalls, the result is held in the output register, one
// further item waits in the read stage, and item ready then drops.
module multi_channel_led_fade_ramp_top #(
  parameter int CHANNELS  = 4,
  parameter int STEP_SIZE = 2
) (
  input logic            clk,
  input logic            rst,
  mclfr_item_if.sink     item,
  mclfr_result_if.source result
);
  import mclfr_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic             item_accept;
  logic [AW+1:0]    item_ch_wide;
  logic [AW+1:0]    s1_ch_wide;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;

  logic             s1_valid;
  logic             s1_kind;
  logic [CH_W-1:0]  s1_channel;
  logic [LVL_W-1:0] s1_target;
  logic             s1_adv;
  logic             s1_in_range;

  logic             res_valid;
  result_t          res_q;
  result_t          res_next;
  rec_t             cur_rec;
  rec_t             nxt_rec;

  assign item_accept  = item.valid && item.ready;
  assign item_ch_wide = (AW+2)'(item.channel);
  assign rd_addr      = item_ch_wide[AW-1:0];
  assign s1_ch_wide   = (AW+2)'(s1_channel);
  assign wr_addr      = s1_ch_wide[AW-1:0];
  assign s1_in_range  = 32'(s1_channel) < CHANNELS;

  assign s1_adv     = s1_valid && (!res_valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (item_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_kind    <= item.kind;
      s1_channel <= item.channel;
      s1_target  <= item.target_level;
    end
    if (s1_adv) begin
      res_q <= res_next;
    end
  end

  mclfr_state_mem #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (item_accept),
    .rd_addr (rd_addr),
    .wr_en   (s1_adv && s1_in_range),
    .wr_addr (wr_addr),
    .wr_rec  (nxt_rec),
    .rd_rec  (cur_rec)
  );

  mclfr_update #(
    .STEP_SIZE (STEP_SIZE)
  ) u_update (
    .kind         (s1_kind),
    .channel      (s1_channel),
    .target_level (s1_target),
    .in_range     (s1_in_range),
    .cur          (cur_rec),
    .nxt          (nxt_rec),
    .res          (res_next)
  );

  assign result.valid         = res_valid;
  assign result.out_channel   = res_q.out_channel;
  assign result.pwm_level     = res_q.pwm_level;
  assign result.level_written = res_q.level_written;
  assign result.fading        = res_q.fading;

  a_reset_empties_pipe: assert property (@(posedge clk) rst |=> (!s1_valid && !res_valid))
    else $error("pipeline not empty after reset");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> res_valid)
    else $error("advanced beat did not reach the output register");

  a_fading_implies_written_or_set: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_kind == KIND_TICK && res_next.fading) |-> res_next.level_written)
    else $error("tick left a channel fading without a step");

endmodule
